// ===== src/csn_pkg.sv =====
// ----------------------------------------------------------------------------
// csn_pkg: shared constants and types for the cylinder surface normal block
// Widths of the normalised datapath and the side data carried down the cells.
// ----------------------------------------------------------------------------
package csn_pkg;

  // Default coordinate width (Q16.16)
  localparam int COORD_WIDTH_DEF = 32;

  // Normalised magnitudes before and after the cross term
  localparam int PRE_BITS  = 20;
  localparam int POST_BITS = 30;
  localparam int OUT_FRAC  = 14;

  // Square root chain: radicand, root and partial remainder widths
  localparam int RAD_W  = 2 * POST_BITS + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 1;

  // Divider chain: quotient bits and numerator width
  localparam int QUO_W = OUT_FRAC + 1;
  localparam int NUM_W = ROOT_W + QUO_W;

  // Output component width
  localparam int NRM_W = 16;

  // Side data travelling with the square root cells
  typedef struct packed {
    logic                          deg;
    logic [2:0]                    sgn;
    logic [2:0][POST_BITS-1:0]     m;
  } sq_side_t;

  // Side data travelling with the divider cells
  typedef struct packed {
    logic       deg;
    logic [2:0] sgn;
  } dv_side_t;

endpackage

// ===== src/csn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// csn_sqrt_cell: one bit of the integer square root
// Brings down two radicand bits, tries the next root bit and registers.
// ----------------------------------------------------------------------------
module csn_sqrt_cell
  import csn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [REM_W-1:0]  in_rem,
  input  logic [ROOT_W-1:0] in_root,
  input  logic [RAD_W-1:0]  in_rad,
  input  sq_side_t          in_side,
  output logic              out_valid,
  output logic [REM_W-1:0]  out_rem,
  output logic [ROOT_W-1:0] out_root,
  output logic [RAD_W-1:0]  out_rad,
  output sq_side_t          out_side
);

  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;

  // Try the next root bit
  always_comb begin
    rem2  = {in_rem, in_rad[RAD_W-1 -: 2]};
    trial = {1'b0, in_root, 2'b01};
    diff  = rem2 - trial;
    ge    = (rem2 >= trial);
  end

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Advance the beat
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
      out_root <= {in_root[ROOT_W-2:0], ge};
      out_rad  <= {in_rad[RAD_W-3:0], 2'b00};
      out_side <= in_side;
    end
  end

endmodule

// ===== src/csn_div_cell.sv =====
// ----------------------------------------------------------------------------
// csn_div_cell: one quotient bit for all three lanes
// Restoring division step against the shared vector length.
// ----------------------------------------------------------------------------
module csn_div_cell
  import csn_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [2:0][ROOT_W-1:0]      in_r,
  input  logic [2:0][QUO_W-1:0]       in_lo,
  input  logic [2:0][QUO_W-1:0]       in_q,
  input  logic [ROOT_W-1:0]           in_len,
  input  dv_side_t                    in_side,
  output logic                        out_valid,
  output logic [2:0][ROOT_W-1:0]      out_r,
  output logic [2:0][QUO_W-1:0]       out_lo,
  output logic [2:0][QUO_W-1:0]       out_q,
  output logic [ROOT_W-1:0]           out_len,
  output dv_side_t                    out_side
);

  logic [2:0][ROOT_W:0]   r2;
  logic [2:0][ROOT_W:0]   diff;
  logic [2:0]             ge;

  // Shift in the next numerator bit and compare per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2[i]   = {in_r[i], in_lo[i][QUO_W-1]};
      diff[i] = r2[i] - {1'b0, in_len};
      ge[i]   = (r2[i] >= {1'b0, in_len});
    end
  end

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Advance the beat
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_r[i]  <= ge[i] ? diff[i][ROOT_W-1:0] : r2[i][ROOT_W-1:0];
        out_lo[i] <= {in_lo[i][QUO_W-2:0], 1'b0};
        out_q[i]  <= {in_q[i][QUO_W-2:0], ge[i]};
      end
      out_len  <= in_len;
      out_side <= in_side;
    end
  end

endmodule

// ===== src/cylinder_surface_normal.sv =====
// ----------------------------------------------------------------------------
// cylinder_surface_normal: inward unit normal of an infinite cylinder
// Projects the hit point onto the axis and returns the Q1.14 unit vector
// from the hit point toward the foot, with a flag for degenerate input.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                  tuser
//  s_*       in   hit xyz, axis xyz, base xyz (Q16.16)   -
//  m_*       out  normal x, y, z (Q1.14)                 degenerate
//
//  One beat per cycle sustained while m_tready is high. The pipeline has 13
//  front stages (rescale, dot products, split 44x21 products, length squared),
//  31 square root cells, one numerator stage, 15 divider cells and the output register.
//  Reset clears every valid bit; payload registers are not reset.
//  A stall on m_tready freezes the whole pipeline and drops s_tready.
// ----------------------------------------------------------------------------
module cylinder_surface_normal
  import csn_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // hit_x, hit_y, hit_z, axis_x, axis_y, axis_z, base_x, base_y, base_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // normal_x, normal_y, normal_z
  output logic [3*NRM_W-1:0]                    m_tdata,
  // degenerate
  output logic                                  m_tuser
);

  localparam int CW     = COORD_WIDTH;
  localparam int MW     = CW + 1;
  localparam int SW1    = MW + PRE_BITS;
  localparam int PW1    = $clog2(SW1);
  localparam int AW     = PRE_BITS + 1;
  localparam int PW_    = 2 * AW;
  localparam int SUM_W  = PW_ + 2;
  localparam int HW     = SUM_W / 2;
  localparam int WW     = 3 * AW + 3;
  localparam int WM     = WW - 1;
  localparam int SW2    = WM + POST_BITS;
  localparam int PW2    = $clog2(SW2);
  localparam int SQ_W   = 2 * POST_BITS;
  localparam int NFRONT = 13;

  logic en;
  logic [NFRONT-1:0] vp;

  // Advance whenever the output register is free or being drained
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[NFRONT-2:0], s_tvalid};
    end
  end

  // Stage 1: difference, magnitudes and zero checks
  logic [2:0][MW-1:0] ma_c, md_c, ma1, md1;
  logic [2:0]         sa_c, sd_c, sa1, sd1;
  logic               deg_c, deg1;

  always_comb begin
    logic signed [MW-1:0] av, dv;
    logic                 az, dz;
    az = 1'b1;
    dz = 1'b1;
    for (int i = 0; i < 3; i++) begin
      av = MW'($signed(s_tdata[(3+i)*CW +: CW]));
      dv = MW'($signed(s_tdata[i*CW +: CW])) - MW'($signed(s_tdata[(6+i)*CW +: CW]));
      sa_c[i] = av[MW-1];
      sd_c[i] = dv[MW-1];
      ma_c[i] = av[MW-1] ? -av : av;
      md_c[i] = dv[MW-1] ? -dv : dv;
      az = az && (av == '0);
      dz = dz && (dv == '0);
    end
    deg_c = az || dz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma1  <= ma_c;
      md1  <= md_c;
      sa1  <= sa_c;
      sd1  <= sd_c;
      deg1 <= deg_c;
    end
  end

  // Stage 2: leading one of each vector
  logic [PW1-1:0]     pa_c, pd_c, pa2, pd2;
  logic [2:0][MW-1:0] ma2, md2;
  logic [2:0]         sa2, sd2;
  logic               deg2;

  always_comb begin
    logic [MW-1:0] ora, ord;
    ora  = ma1[0] | ma1[1] | ma1[2];
    ord  = md1[0] | md1[1] | md1[2];
    pa_c = '0;
    pd_c = '0;
    for (int j = 0; j < MW; j++) begin
      if (ora[j]) pa_c = PW1'(j);
      if (ord[j]) pd_c = PW1'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa2  <= pa_c;
      pd2  <= pd_c;
      ma2  <= ma1;
      md2  <= md1;
      sa2  <= sa1;
      sd2  <= sd1;
      deg2 <= deg1;
    end
  end

  // Stage 3: rescale both vectors to PRE_BITS magnitude, restore sign
  logic signed [2:0][AW-1:0] a_c, d_c, a3, d3;
  logic                      deg3;

  always_comb begin
    logic [SW1-1:0]      ea, ed;
    logic signed [AW-1:0] ta, td;
    for (int i = 0; i < 3; i++) begin
      ea = {{PRE_BITS{1'b0}}, ma2[i]};
      ed = {{PRE_BITS{1'b0}}, md2[i]};
      if (pa2 >= PW1'(PRE_BITS - 1)) ea = ea >> (pa2 - PW1'(PRE_BITS - 1));
      else                           ea = ea << (PW1'(PRE_BITS - 1) - pa2);
      if (pd2 >= PW1'(PRE_BITS - 1)) ed = ed >> (pd2 - PW1'(PRE_BITS - 1));
      else                           ed = ed << (PW1'(PRE_BITS - 1) - pd2);
      ta = {1'b0, ea[PRE_BITS-1:0]};
      td = {1'b0, ed[PRE_BITS-1:0]};
      a_c[i] = sa2[i] ? -ta : ta;
      d_c[i] = sd2[i] ? -td : td;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3   <= a_c;
      d3   <= d_c;
      deg3 <= deg2;
    end
  end

  // Stage 4: element products for a.d and a.a
  logic signed [2:0][PW_-1:0] pad4, paa4;
  logic signed [2:0][AW-1:0]  a4, d4;
  logic                       deg4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pad4[i] <= $signed(a3[i]) * $signed(d3[i]);
        paa4[i] <= $signed(a3[i]) * $signed(a3[i]);
      end
      a4   <= a3;
      d4   <= d3;
      deg4 <= deg3;
    end
  end

  // Stage 5: dot products
  logic signed [SUM_W-1:0]   ad5, aa5;
  logic signed [2:0][AW-1:0] a5, d5;
  logic                      deg5;

  always_ff @(posedge clk) begin
    if (en) begin
      ad5  <= SUM_W'($signed(pad4[0])) + SUM_W'($signed(pad4[1]))
              + SUM_W'($signed(pad4[2]));
      aa5  <= SUM_W'($signed(paa4[0])) + SUM_W'($signed(paa4[1]))
              + SUM_W'($signed(paa4[2]));
      a5   <= a4;
      d5   <= d4;
      deg5 <= deg4;
    end
  end

  // Stage 6: split products (ad*a_i and aa*d_i) in high and low halves
  logic signed [2:0][SUM_W-HW+AW-1:0] ph6, qh6;
  logic signed [2:0][HW+AW:0]         pl6, ql6;
  logic                               deg6;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ph6[i] <= $signed(ad5[SUM_W-1:HW]) * $signed(a5[i]);
        pl6[i] <= $signed({1'b0, ad5[HW-1:0]}) * $signed(a5[i]);
        qh6[i] <= $signed(aa5[SUM_W-1:HW]) * $signed(d5[i]);
        ql6[i] <= $signed({1'b0, aa5[HW-1:0]}) * $signed(d5[i]);
      end
      deg6 <= deg5;
    end
  end

  // Stage 7: recombine the halves
  logic signed [2:0][WW-1:0] t17, t27;
  logic                      deg7;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t17[i] <= (WW'($signed(ph6[i])) <<< HW) + WW'($signed(pl6[i]));
        t27[i] <= (WW'($signed(qh6[i])) <<< HW) + WW'($signed(ql6[i]));
      end
      deg7 <= deg6;
    end
  end

  // Stage 8: w = (a.d) a - (a.a) d
  logic signed [2:0][WW-1:0] w8;
  logic                      deg8;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        w8[i] <= $signed(t17[i]) - $signed(t27[i]);
      end
      deg8 <= deg7;
    end
  end

  // Stage 9: magnitudes of w, flag a hit on the axis
  logic [2:0][WM-1:0] mw_c, mw9;
  logic [2:0]         sw9;
  logic [WM-1:0]      orw9;
  logic               deg9;

  always_comb begin
    logic signed [WW-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t       = w8[i][WW-1] ? -$signed(w8[i]) : $signed(w8[i]);
      mw_c[i] = t[WM-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mw9 <= mw_c;
      orw9 <= mw_c[0] | mw_c[1] | mw_c[2];
      for (int i = 0; i < 3; i++) begin
        sw9[i] <= w8[i][WW-1];
      end
      deg9 <= deg8 || (w8 == '0);
    end
  end

  // Stage 10: leading one of w
  logic [PW2-1:0]     pw_c, pw10;
  logic [2:0][WM-1:0] mw10;
  logic [2:0]         sw10;
  logic               deg10;

  always_comb begin
    pw_c = '0;
    for (int j = 0; j < WM; j++) begin
      if (orw9[j]) pw_c = PW2'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw10  <= pw_c;
      mw10  <= mw9;
      sw10  <= sw9;
      deg10 <= deg9;
    end
  end

  // Stage 11: rescale w to POST_BITS magnitude
  logic [2:0][POST_BITS-1:0] m_c, m11;
  logic [2:0]                sw11;
  logic                      deg11;

  always_comb begin
    logic [SW2-1:0] e;
    for (int i = 0; i < 3; i++) begin
      e = {{POST_BITS{1'b0}}, mw10[i]};
      if (pw10 >= PW2'(POST_BITS - 1)) e = e >> (pw10 - PW2'(POST_BITS - 1));
      else                             e = e << (PW2'(POST_BITS - 1) - pw10);
      m_c[i] = e[POST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m11   <= m_c;
      sw11  <= sw10;
      deg11 <= deg10;
    end
  end

  // Stage 12: squares
  logic [2:0][SQ_W-1:0]      sq12;
  logic [2:0][POST_BITS-1:0] m12;
  logic [2:0]                sw12;
  logic                      deg12;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq12[i] <= m11[i] * m11[i];
      end
      m12   <= m11;
      sw12  <= sw11;
      deg12 <= deg11;
    end
  end

  // Stage 13: length squared
  logic [RAD_W-1:0] sum13;
  sq_side_t         side13;

  always_ff @(posedge clk) begin
    if (en) begin
      sum13      <= RAD_W'(sq12[0]) + RAD_W'(sq12[1]) + RAD_W'(sq12[2]);
      side13.deg <= deg12;
      side13.sgn <= sw12;
      side13.m   <= m12;
    end
  end

  // Square root chain, one root bit per cell
  logic     [ROOT_W:0]             sq_v;
  logic     [ROOT_W:0][REM_W-1:0]  sq_rem;
  logic     [ROOT_W:0][ROOT_W-1:0] sq_root;
  logic     [ROOT_W:0][RAD_W-1:0]  sq_rad;
  sq_side_t [ROOT_W:0]             sq_side;

  assign sq_v[0]    = vp[NFRONT-1];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = sum13;
  assign sq_side[0] = side13;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    csn_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sq_v[k]),
      .in_rem   (sq_rem[k]),
      .in_root  (sq_root[k]),
      .in_rad   (sq_rad[k]),
      .in_side  (sq_side[k]),
      .out_valid(sq_v[k+1]),
      .out_rem  (sq_rem[k+1]),
      .out_root (sq_root[k+1]),
      .out_rad  (sq_rad[k+1]),
      .out_side (sq_side[k+1])
    );
  end

  // Numerator stage: |w_i| * 2^14 + floor(L/2)
  logic                           vn;
  logic     [2:0][ROOT_W-1:0]     nr;
  logic     [2:0][QUO_W-1:0]      nlo;
  logic     [ROOT_W-1:0]          nlen;
  dv_side_t                       nside;
  logic     [QUO_W:0]             dv_v;
  logic     [QUO_W:0][2:0][ROOT_W-1:0] dv_r;
  logic     [QUO_W:0][2:0][QUO_W-1:0]  dv_lo;
  logic     [QUO_W:0][2:0][QUO_W-1:0]  dv_q;
  logic     [QUO_W:0][ROOT_W-1:0]      dv_len;
  dv_side_t [QUO_W:0]                  dv_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (en) begin
      vn <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] num;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num = (NUM_W'(sq_side[ROOT_W].m[i]) << OUT_FRAC)
              + NUM_W'(sq_root[ROOT_W] >> 1);
        nr[i]  <= num[NUM_W-1:QUO_W];
        nlo[i] <= num[QUO_W-1:0];
      end
      nlen      <= sq_root[ROOT_W];
      nside.deg <= sq_side[ROOT_W].deg;
      nside.sgn <= sq_side[ROOT_W].sgn;
    end
  end

  assign dv_v[0]    = vn;
  assign dv_r[0]    = nr;
  assign dv_lo[0]   = nlo;
  assign dv_q[0]    = '0;
  assign dv_len[0]  = nlen;
  assign dv_side[0] = nside;

  // Divider chain, one quotient bit per cell
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    csn_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv_v[k]),
      .in_r     (dv_r[k]),
      .in_lo    (dv_lo[k]),
      .in_q     (dv_q[k]),
      .in_len   (dv_len[k]),
      .in_side  (dv_side[k]),
      .out_valid(dv_v[k+1]),
      .out_r    (dv_r[k+1]),
      .out_lo   (dv_lo[k+1]),
      .out_q    (dv_q[k+1]),
      .out_len  (dv_len[k+1]),
      .out_side (dv_side[k+1])
    );
  end

  // Output register: apply sign, zero the normal when degenerate
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_v[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    logic [NRM_W-1:0] qx;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qx = NRM_W'(dv_q[QUO_W][i]);
        if (dv_side[QUO_W].deg) begin
          m_tdata[i*NRM_W +: NRM_W] <= '0;
        end else begin
          m_tdata[i*NRM_W +: NRM_W] <= dv_side[QUO_W].sgn[i] ? -qx : qx;
        end
      end
      m_tuser <= dv_side[QUO_W].deg;
    end
  end

`ifndef SYNTHESIS
  a_deg_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate beat carries a nonzero normal");

  a_norm_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[NRM_W-1:0]) <= 16384
                  && $signed(m_tdata[NRM_W-1:0]) >= -16384
                  && $signed(m_tdata[2*NRM_W-1:NRM_W]) <= 16384
                  && $signed(m_tdata[2*NRM_W-1:NRM_W]) >= -16384
                  && $signed(m_tdata[3*NRM_W-1:2*NRM_W]) <= 16384
                  && $signed(m_tdata[3*NRM_W-1:2*NRM_W]) >= -16384))
    else $error("normal component out of range");

  a_len_floor : assert property (@(posedge clk) disable iff (rst)
    sq_v[ROOT_W] && !sq_side[ROOT_W].deg
    |-> sq_root[ROOT_W][ROOT_W-1:POST_BITS-1] != '0)
    else $error("vector length below the rescaled minimum");
`endif

endmodule
